// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the frame receiver RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cons in the same cycle as ante, outside reset.
`define RPCFR_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rpcfr assertion failed");

// Check cons in the cycle after ante, outside reset.
`define RPCFR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rpcfr assertion failed");

`endif

// ----- hdl/rpcfr_pkg.sv -----
// Types, codes and the CRC step shared by the frame receiver.
`timescale 1ns / 1ps
`default_nettype none
package rpcfr_pkg;

  localparam logic [15:0] CRC_INIT = 16'hEF4A;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] STALL_LIMIT_RESET = 16'd200;
  localparam logic [15:0] MAX_BODY_RESET = 16'd4096;
  localparam logic [15:0] MSG_HDR_BYTES = 16'd8;
  localparam logic [7:0]  VERSION_ONE = 8'd1;
  localparam logic [7:0]  TYPE_REPLY = 8'd2;
  localparam logic [2:0]  HDR_BYTES = 3'd4;
  localparam logic [2:0]  HDR_LAST = 3'd3;

  // Item kinds
  localparam logic [1:0] MODE_BYTE = 2'd0;
  localparam logic [1:0] MODE_TICK = 2'd1;
  localparam logic [1:0] MODE_OVF  = 2'd2;

  // Verdict codes
  localparam logic [2:0] ST_REPLY_OK  = 3'd0;
  localparam logic [2:0] ST_CRC_FAIL  = 3'd1;
  localparam logic [2:0] ST_BAD_VER   = 3'd2;
  localparam logic [2:0] ST_TOO_SHORT = 3'd3;
  localparam logic [2:0] ST_NOT_REPLY = 3'd4;
  localparam logic [2:0] ST_OVERSIZE  = 3'd5;
  localparam logic [2:0] ST_STALLED   = 3'd6;
  localparam logic [2:0] ST_LOST      = 3'd7;

  // Configuration register indexes
  localparam logic CFG_STALL_LIMIT = 1'b0;
  localparam logic CFG_MAX_BODY    = 1'b1;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] sequence_res;
    logic [7:0]  service_id;
    logic [7:0]  request_id;
    logic [7:0]  message_type;
    logic [15:0] payload_length;
  } res_t;

  // CRC-16 over one byte, MSB first.
  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] x;
    x = c ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (x[15]) begin
        x = {x[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        x = {x[14:0], 1'b0};
      end
    end
    return x;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/rpcfr_in_stage.sv -----
// Input register of the frame receiver.
`timescale 1ns / 1ps
`default_nettype none
module rpcfr_in_stage (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire logic [1:0]     in_mode,
  input  wire logic [7:0]     in_data_byte,
  input  wire logic           adv,
  output logic                s1_valid,
  output rpcfr_pkg::item_t    s1_item
);

  logic             valid_r, valid_nxt;
  rpcfr_pkg::item_t item_r;
  logic             take;

  assign in_stall = valid_r & ~adv;
  assign take     = in_valid & ~in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (adv) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r.mode      <= in_mode;
      item_r.data_byte <= in_data_byte;
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;

endmodule
`default_nettype wire

// ----- hdl/rpcfr_core.sv -----
// Frame parser: header capture, running CRC, drain, stall timer and verdict.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module rpcfr_core (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_valid,
  input  wire logic             cfg_index,
  input  wire logic [15:0]      cfg_data,
  input  wire logic             fire,
  input  wire rpcfr_pkg::item_t item,
  output logic                  res_valid,
  output rpcfr_pkg::res_t       res
);

  logic [15:0] stall_limit_r, max_body_r;
  logic [2:0]  header_count_r, header_count_nxt;
  logic [15:0] frame_length_r, frame_length_nxt;
  logic [15:0] expected_crc_r, expected_crc_nxt;
  logic [15:0] body_count_r, body_count_nxt;
  logic [15:0] running_crc_r, running_crc_nxt;
  logic [31:0] message_header_r, message_header_nxt;
  logic [31:0] sequence_word_r, sequence_word_nxt;
  logic [15:0] drain_left_r, drain_left_nxt;
  logic        frame_active_r, frame_active_nxt;
  logic [15:0] idle_ticks_r, idle_ticks_nxt;
  logic        do_idle;
  logic [15:0] ticks_inc;
  logic [15:0] body_inc;
  logic [7:0]  b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stall_limit_r <= rpcfr_pkg::STALL_LIMIT_RESET;
      max_body_r    <= rpcfr_pkg::MAX_BODY_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rpcfr_pkg::CFG_STALL_LIMIT: stall_limit_r <= cfg_data;
        rpcfr_pkg::CFG_MAX_BODY:    max_body_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    b                  = item.data_byte;
    header_count_nxt   = header_count_r;
    frame_length_nxt   = frame_length_r;
    expected_crc_nxt   = expected_crc_r;
    body_count_nxt     = body_count_r;
    running_crc_nxt    = running_crc_r;
    message_header_nxt = message_header_r;
    sequence_word_nxt  = sequence_word_r;
    drain_left_nxt     = drain_left_r;
    frame_active_nxt   = frame_active_r;
    idle_ticks_nxt     = idle_ticks_r;
    do_idle            = 1'b0;
    res_valid          = 1'b0;
    res                = '0;
    ticks_inc = (idle_ticks_r == 16'hFFFF) ? idle_ticks_r : idle_ticks_r + 16'd1;
    body_inc  = body_count_r + 16'd1;

    if (fire) begin
      unique case (item.mode)
        rpcfr_pkg::MODE_TICK: begin
          if (frame_active_r) begin
            idle_ticks_nxt = ticks_inc;
            if (ticks_inc >= stall_limit_r) begin
              do_idle    = 1'b1;
              res_valid  = 1'b1;
              res.status = rpcfr_pkg::ST_STALLED;
            end
          end
        end
        rpcfr_pkg::MODE_OVF: begin
          do_idle = 1'b1;
          if (frame_active_r) begin
            res_valid  = 1'b1;
            res.status = rpcfr_pkg::ST_LOST;
          end
        end
        rpcfr_pkg::MODE_BYTE: begin
          idle_ticks_nxt   = '0;
          frame_active_nxt = 1'b1;
          if (drain_left_r != '0) begin
            drain_left_nxt = drain_left_r - 16'd1;
            if (drain_left_r == 16'd1) begin
              do_idle = 1'b1;
            end
          end else if (header_count_r < rpcfr_pkg::HDR_BYTES) begin
            case (header_count_r[1:0])
              2'd0:    frame_length_nxt = {8'h00, b};
              2'd1:    frame_length_nxt = {b, frame_length_r[7:0]};
              2'd2:    expected_crc_nxt = {8'h00, b};
              default: expected_crc_nxt = {b, expected_crc_r[7:0]};
            endcase
            header_count_nxt = header_count_r + 3'd1;
            if (header_count_r == rpcfr_pkg::HDR_LAST) begin
              body_count_nxt  = '0;
              running_crc_nxt = rpcfr_pkg::CRC_INIT;
              if (frame_length_r > max_body_r) begin
                drain_left_nxt = frame_length_r;
                res_valid      = 1'b1;
                res.status     = rpcfr_pkg::ST_OVERSIZE;
              end else if (frame_length_r < rpcfr_pkg::MSG_HDR_BYTES) begin
                do_idle    = 1'b1;
                res_valid  = 1'b1;
                res.status = rpcfr_pkg::ST_TOO_SHORT;
              end
            end
          end else begin
            running_crc_nxt = rpcfr_pkg::crc_byte(running_crc_r, b);
            if (body_count_r < 16'd4) begin
              message_header_nxt[{body_count_r[1:0], 3'b000} +: 8] = b;
            end else if (body_count_r < 16'd8) begin
              sequence_word_nxt[{body_count_r[1:0], 3'b000} +: 8] = b;
            end
            body_count_nxt = body_inc;
            if (body_inc >= frame_length_r) begin
              do_idle   = 1'b1;
              res_valid = 1'b1;
              if (running_crc_nxt != expected_crc_r) begin
                res.status = rpcfr_pkg::ST_CRC_FAIL;
              end else if (message_header_nxt[31:24] != rpcfr_pkg::VERSION_ONE) begin
                res.status = rpcfr_pkg::ST_BAD_VER;
              end else if (message_header_nxt[7:0] != rpcfr_pkg::TYPE_REPLY) begin
                res.status = rpcfr_pkg::ST_NOT_REPLY;
              end else begin
                res.status = rpcfr_pkg::ST_REPLY_OK;
              end
              res.sequence_res   = sequence_word_nxt;
              res.service_id     = message_header_nxt[23:16];
              res.request_id     = message_header_nxt[15:8];
              res.message_type   = message_header_nxt[7:0];
              res.payload_length = frame_length_r - rpcfr_pkg::MSG_HDR_BYTES;
            end
          end
        end
        default: ;
      endcase
    end

    // Drop back to idle after a verdict, at the end of a drain, or on an overflow notice.
    if (do_idle) begin
      header_count_nxt   = '0;
      frame_length_nxt   = '0;
      expected_crc_nxt   = '0;
      body_count_nxt     = '0;
      running_crc_nxt    = rpcfr_pkg::CRC_INIT;
      message_header_nxt = '0;
      sequence_word_nxt  = '0;
      drain_left_nxt     = '0;
      frame_active_nxt   = 1'b0;
      idle_ticks_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_count_r   <= '0;
      frame_length_r   <= '0;
      expected_crc_r   <= '0;
      body_count_r     <= '0;
      running_crc_r    <= rpcfr_pkg::CRC_INIT;
      message_header_r <= '0;
      sequence_word_r  <= '0;
      drain_left_r     <= '0;
      frame_active_r   <= 1'b0;
      idle_ticks_r     <= '0;
    end else begin
      header_count_r   <= header_count_nxt;
      frame_length_r   <= frame_length_nxt;
      expected_crc_r   <= expected_crc_nxt;
      body_count_r     <= body_count_nxt;
      running_crc_r    <= running_crc_nxt;
      message_header_r <= message_header_nxt;
      sequence_word_r  <= sequence_word_nxt;
      drain_left_r     <= drain_left_nxt;
      frame_active_r   <= frame_active_nxt;
      idle_ticks_r     <= idle_ticks_nxt;
    end
  end

  `RPCFR_ASSERT_SAME(a_hdr_count_range, 1'b1, header_count_r <= rpcfr_pkg::HDR_BYTES)
  `RPCFR_ASSERT_SAME(a_drain_in_frame, drain_left_r != '0,
                     frame_active_r && (header_count_r == rpcfr_pkg::HDR_BYTES))
  `RPCFR_ASSERT_SAME(a_idle_clean, !frame_active_r,
                     (header_count_r == '0) && (idle_ticks_r == '0))

endmodule
`default_nettype wire

// ----- hdl/rpcfr_out_reg.sv -----
// Result register of the frame receiver.
`timescale 1ns / 1ps
`default_nettype none
module rpcfr_out_reg (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            adv,
  input  wire logic            res_valid,
  input  wire rpcfr_pkg::res_t res,
  input  wire logic            out_stall,
  output logic                 out_valid,
  output rpcfr_pkg::res_t      out_res
);

  logic            valid_r, valid_nxt;
  rpcfr_pkg::res_t res_r;

  always_comb begin
    valid_nxt = valid_r;
    if (adv) begin
      valid_nxt = res_valid;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule
`default_nettype wire

// ----- hdl/rpc_frame_receiver.sv -----
// Top level of the framed RPC receive path: input register, parser, result register.
//
// Use: feed one word per accepted cycle on the in_ channel. in_mode selects a
// received UART byte (in_data_byte), a one millisecond tick or a receive
// overflow notice. Each frame is a 4-byte little-endian header (body length,
// body CRC) then the body. The block gives at most one result word per input
// word on the out_ channel: a verdict at the end of a body, too short or
// oversize at the end of the header, stalled after stall_limit ticks without
// a byte, or lost bytes on an overflow notice during a frame.
// Path: an input word is held in the input register, then its result in the
// result register; a stall on out_ can hold the word between the two.
// Throughput: one input word per cycle unless out_stall holds a result; the parser
// (CRC step and header capture) is a single combinational pass between the two regs.
// Stall: while out_stall holds a result, the input register fills and then
// in_stall rises, so a backlog of at most one word waits inside the block.
// Reset (rst_n low, synchronous): both channels empty, parser idle, CRC at
// its seed, stall_limit back to 200 and max_body back to 4096.
// Configuration: cfg_ready is always high; write only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module rpc_frame_receiver (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_mode,
  input  wire logic [7:0]  in_data_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_status,
  output logic [31:0]      out_sequence_res,
  output logic [7:0]       out_service_id,
  output logic [7:0]       out_request_id,
  output logic [7:0]       out_message_type,
  output logic [15:0]      out_payload_length,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data
);

  logic             s1_valid;
  rpcfr_pkg::item_t s1_item;
  logic             adv;
  logic             core_res_valid;
  rpcfr_pkg::res_t  core_res;
  rpcfr_pkg::res_t  out_res;

  // Advance the held word once the result register is empty or draining.
  assign adv       = s1_valid & (~out_valid | ~out_stall);
  assign cfg_ready = 1'b1;

  rpcfr_in_stage u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_mode      (in_mode),
    .in_data_byte (in_data_byte),
    .adv          (adv),
    .s1_valid     (s1_valid),
    .s1_item      (s1_item)
  );

  rpcfr_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fire      (adv),
    .item      (s1_item),
    .res_valid (core_res_valid),
    .res       (core_res)
  );

  rpcfr_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .res_valid (core_res_valid),
    .res       (core_res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign out_status         = out_res.status;
  assign out_sequence_res   = out_res.sequence_res;
  assign out_service_id     = out_res.service_id;
  assign out_request_id     = out_res.request_id;
  assign out_message_type   = out_res.message_type;
  assign out_payload_length = out_res.payload_length;

  `RPCFR_ASSERT_SAME(a_stall_needs_word, in_stall, s1_valid && out_valid && out_stall)
  `RPCFR_ASSERT_NEXT(a_result_lands, adv && core_res_valid, out_valid)
  `RPCFR_ASSERT_NEXT(a_no_result_clears, adv && !core_res_valid, !out_valid)

endmodule
`default_nettype wire
